FILE: rtl/core/ssnt_pkg.sv
`timescale 1ns / 1ps

package ssnt_pkg;

	localparam int WORD_W     = 64;
	localparam int WORD_IDX_W = 6;
	localparam int TARGET_W   = 14;
	localparam int DIFF_W     = 14;
	localparam int DIFF_MAX   = 16383;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	// register index, decoded from paddr[2]
	localparam int REG_TARGET = 0;

	localparam logic [WORD_W-1:0] WORD_ONES = '1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FINAL = 4'b1000
	} ctl_state_t;

endpackage

FILE: rtl/core/ssnt_set_ram.sv
`timescale 1ns / 1ps

module ssnt_set_ram #(
	parameter int DEPTH  = 128,
	parameter int ADDR_W = 7
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [ssnt_pkg::WORD_W-1:0] wdata,
	input  logic [ADDR_W-1:0]           raddr_a,
	input  logic [ADDR_W-1:0]           raddr_b,
	output logic [ssnt_pkg::WORD_W-1:0] rdata_a,
	output logic [ssnt_pkg::WORD_W-1:0] rdata_b
);
	import ssnt_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: rtl/core/signed_sum_nearest_target.sv
// channel  | handshake                 | payload
// item     | item_valid / item_stall   | value, last
// result   | result_valid / result_stall | min_difference, overflow
// config   | APB psel/penable/pready   | target at byte 0
//
// Each word that is added sweeps the reachable-sum set one 64-bit memory row
// per cycle, ping-ponging between two set RAMs; after a last word the block
// also passes through ST_FINAL. A word beyond MAX_ITEMS that is not last is
// dropped without a sweep and sets the overflow flag. No clearing pass: the
// set after reset or list end is produced by read substitution. Reset is
// asynchronous, active low. A pending result does not block the next word.
`timescale 1ns / 1ps

module signed_sum_nearest_target #(
	parameter int MAX_ITEMS  = 16,
	parameter int VALUE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [VALUE_BITS-1:0]         value,
	input  logic                          last,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [ssnt_pkg::DIFF_W-1:0]   min_difference,
	output logic                          overflow,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssnt_pkg::APB_AW-1:0]   paddr,
	input  logic [ssnt_pkg::APB_DW-1:0]   pwdata,
	output logic [ssnt_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import ssnt_pkg::*;

	localparam int VALUE_MAX = (1 << VALUE_BITS) - 1;
	localparam int SUM_LIMIT = MAX_ITEMS * VALUE_MAX;
	localparam int SUM_BITS  = 2 * SUM_LIMIT + 1;
	localparam int WORDS     = (SUM_BITS + WORD_W - 1) / WORD_W;
	localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CNT_W     = $clog2(WORDS + 1);
	localparam int VEXT_W    = VALUE_BITS + WORD_IDX_W;
	localparam int SA_W      = ((CNT_W > VALUE_BITS) ? CNT_W : VALUE_BITS) + 2;
	localparam int LAST_BITS = SUM_BITS - (WORDS - 1) * WORD_W;
	localparam int SEED_WORD = SUM_LIMIT / WORD_W;
	localparam int SEED_BIT  = SUM_LIMIT % WORD_W;
	localparam int POS_W     = $clog2(SUM_BITS + 1);
	localparam int PW        = ((POS_W > TARGET_W) ? POS_W : TARGET_W) + 2;
	localparam int ITEM_W    = $clog2(MAX_ITEMS + 1);

	localparam logic [WORD_W-1:0] LAST_MASK = WORD_ONES >> (WORD_W - LAST_BITS);
	localparam logic [WORD_W-1:0] SEED_ONE  = WORD_W'(1) << SEED_BIT;

	ctl_state_t state_q;
	logic [CNT_W-1:0]      c_q;
	logic [VALUE_BITS-1:0] v_q;
	logic                  search_q;
	logic                  fresh_q;
	logic                  src_q;
	logic [ITEM_W-1:0]     item_cnt_q;
	logic                  ovf_q;
	logic [TARGET_W-1:0]   target_q;

	logic                  v_s1;
	logic [CNT_W-1:0]      c_s1;
	logic                  oob_up_s1, oob_dn_s1, seed_up_s1, seed_dn_s1;
	logic [WORD_W-1:0]     prev_up_q, prev_dn_q;

	logic                  v_s2;
	logic [WORD_W-1:0]     nw_s2;
	logic [ADDR_W-1:0]     w_s2;

	logic                  v_s3;
	logic [WORD_W-1:0]     le_s3, ge_s3;
	logic [PW-1:0]         base_s3;

	logic [PW-1:0]         lo_q, hi_q;
	logic                  lo_found_q, hi_found_q;

	logic                  result_valid_q;
	logic [DIFF_W-1:0]     min_diff_q;
	logic                  ovf_out_q;

	logic                  item_acc, result_acc, cfg_wr, pass_done, final_go;
	logic [VEXT_W-1:0]     vext;
	logic [VALUE_BITS-1:0] shift_q;
	logic [WORD_IDX_W-1:0] shift_r;
	logic [SA_W-1:0]       up_a, dn_a;
	logic                  oob_up, oob_dn;
	logic [WORD_W-1:0]     a_rd_up, a_rd_dn, b_rd_up, b_rd_dn;
	logic [WORD_W-1:0]     mem_up, mem_dn, cur_up, cur_dn, up_w, dn_w, new_word;
	logic [2*WORD_W-1:0]   cat_up_shl, cat_dn_shr;
	logic [ADDR_W-1:0]     w1;
	logic                  wr_en;
	logic [PW-1:0]         p_pos, base2, k;
	logic [WORD_W-1:0]     le_mask, ge_mask;
	logic [WORD_IDX_W-1:0] le_idx, ge_idx;
	logic [PW-1:0]         dlo, dhi, best;
	logic [DIFF_W-1:0]     diff_next;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign prdata     = (paddr[2] == 1'(REG_TARGET)) ?
		{{(APB_DW-TARGET_W){target_q[TARGET_W-1]}}, target_q} : '0;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign result_acc = result_valid_q && !result_stall;
	assign result_valid   = result_valid_q;
	assign min_difference = min_diff_q;
	assign overflow       = ovf_out_q;

	// read addresses for the up window (w-q) and the down window (w+q+1), w = c-1
	assign vext    = VEXT_W'(v_q);
	assign shift_q = vext[VEXT_W-1:WORD_IDX_W];
	assign shift_r = vext[WORD_IDX_W-1:0];
	assign up_a    = SA_W'(c_q) - SA_W'(shift_q) - SA_W'(1);
	assign dn_a    = SA_W'(c_q) + SA_W'(shift_q);
	assign oob_up  = up_a[SA_W-1] || (up_a >= SA_W'(WORDS));
	assign oob_dn  = (dn_a >= SA_W'(WORDS));

	assign w1    = ADDR_W'(c_s1 - CNT_W'(1));
	assign wr_en = v_s1 && (c_s1 != '0);

	ssnt_set_ram #(.DEPTH(WORDS), .ADDR_W(ADDR_W)) u_ram_a (
		.clk     (clk),
		.we      (wr_en && src_q),
		.waddr   (w1),
		.wdata   (new_word),
		.raddr_a (up_a[ADDR_W-1:0]),
		.raddr_b (dn_a[ADDR_W-1:0]),
		.rdata_a (a_rd_up),
		.rdata_b (a_rd_dn)
	);

	ssnt_set_ram #(.DEPTH(WORDS), .ADDR_W(ADDR_W)) u_ram_b (
		.clk     (clk),
		.we      (wr_en && !src_q),
		.waddr   (w1),
		.wdata   (new_word),
		.raddr_a (up_a[ADDR_W-1:0]),
		.raddr_b (dn_a[ADDR_W-1:0]),
		.rdata_a (b_rd_up),
		.rdata_b (b_rd_dn)
	);

	always_comb begin
		mem_up = src_q ? b_rd_up : a_rd_up;
		mem_dn = src_q ? b_rd_dn : a_rd_dn;
		if (oob_up_s1) begin
			cur_up = '0;
		end else if (fresh_q) begin
			cur_up = seed_up_s1 ? SEED_ONE : '0;
		end else begin
			cur_up = mem_up;
		end
		if (oob_dn_s1) begin
			cur_dn = '0;
		end else if (fresh_q) begin
			cur_dn = seed_dn_s1 ? SEED_ONE : '0;
		end else begin
			cur_dn = mem_dn;
		end
		cat_up_shl = {cur_up, prev_up_q} << shift_r;
		cat_dn_shr = {cur_dn, prev_dn_q} >> shift_r;
		up_w       = cat_up_shl[2*WORD_W-1:WORD_W];
		dn_w       = cat_dn_shr[WORD_W-1:0];
		new_word   = (up_w | dn_w) & ((w1 == ADDR_W'(WORDS - 1)) ? LAST_MASK : WORD_ONES);
	end

	// target as a bit position, and its offset within the word in stage 2
	assign p_pos = {{(PW-TARGET_W){target_q[TARGET_W-1]}}, target_q} + PW'(SUM_LIMIT);
	assign base2 = PW'({w_s2, {WORD_IDX_W{1'b0}}});
	assign k     = p_pos - base2;

	always_comb begin
		if (k[PW-1]) begin
			le_mask = '0;
			ge_mask = WORD_ONES;
		end else begin
			if (k >= PW'(WORD_W - 1)) begin
				le_mask = WORD_ONES;
			end else begin
				le_mask = WORD_ONES >> (WORD_IDX_W'(WORD_W - 1) - k[WORD_IDX_W-1:0]);
			end
			if (k > PW'(WORD_W - 1)) begin
				ge_mask = '0;
			end else begin
				ge_mask = WORD_ONES << k[WORD_IDX_W-1:0];
			end
		end
	end

	always_comb begin
		le_idx = '0;
		ge_idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (le_s3[i]) begin
				le_idx = WORD_IDX_W'(i);
			end
		end
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (ge_s3[i]) begin
				ge_idx = WORD_IDX_W'(i);
			end
		end
	end

	always_comb begin
		dlo = p_pos - lo_q;
		dhi = hi_q - p_pos;
		if (lo_found_q && hi_found_q) begin
			best = (dlo < dhi) ? dlo : dhi;
		end else if (lo_found_q) begin
			best = dlo;
		end else if (hi_found_q) begin
			best = dhi;
		end else begin
			best = '0;
		end
		diff_next = (best > PW'(DIFF_MAX)) ? DIFF_W'(DIFF_MAX) : best[DIFF_W-1:0];
	end

	assign pass_done = (state_q == ST_DRAIN) && !v_s1 && !v_s2 && !v_s3;
	assign final_go  = (state_q == ST_FINAL) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			c_q            <= '0;
			search_q       <= 1'b0;
			fresh_q        <= 1'b1;
			src_q          <= 1'b0;
			item_cnt_q     <= '0;
			ovf_q          <= 1'b0;
			target_q       <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			lo_found_q     <= 1'b0;
			hi_found_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == 1'(REG_TARGET))) begin
				target_q <= pwdata[TARGET_W-1:0];
			end

			v_s1 <= (state_q == ST_RUN);
			v_s2 <= wr_en;
			v_s3 <= v_s2;

			if (v_s3 && search_q) begin
				if (|le_s3) begin
					lo_found_q <= 1'b1;
				end
				if ((|ge_s3) && !hi_found_q) begin
					hi_found_q <= 1'b1;
				end
			end

			if (final_go) begin
				result_valid_q <= 1'b1;
			end else if (result_acc) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (item_cnt_q < ITEM_W'(MAX_ITEMS)) begin
							item_cnt_q <= item_cnt_q + ITEM_W'(1);
							search_q   <= last;
							c_q        <= '0;
							lo_found_q <= 1'b0;
							hi_found_q <= 1'b0;
							state_q    <= ST_RUN;
						end else begin
							ovf_q <= 1'b1;
							if (last) begin
								search_q   <= 1'b1;
								c_q        <= '0;
								lo_found_q <= 1'b0;
								hi_found_q <= 1'b0;
								state_q    <= ST_RUN;
							end
						end
					end
				end
				ST_RUN: begin
					c_q <= c_q + CNT_W'(1);
					if (c_q == CNT_W'(WORDS)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pass_done) begin
						src_q   <= !src_q;
						fresh_q <= 1'b0;
						state_q <= search_q ? ST_FINAL : ST_IDLE;
					end
				end
				ST_FINAL: begin
					if (final_go) begin
						fresh_q    <= 1'b1;
						item_cnt_q <= '0;
						ovf_q      <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			// a dropped word sweeps with no shift so the set is only searched
			v_q <= (item_cnt_q < ITEM_W'(MAX_ITEMS)) ? value : '0;
		end

		c_s1       <= c_q;
		oob_up_s1  <= oob_up;
		oob_dn_s1  <= oob_dn;
		seed_up_s1 <= (up_a == SA_W'(SEED_WORD));
		seed_dn_s1 <= (dn_a == SA_W'(SEED_WORD));

		if (v_s1) begin
			prev_up_q <= cur_up;
			prev_dn_q <= cur_dn;
		end

		nw_s2 <= new_word;
		w_s2  <= w1;

		le_s3   <= nw_s2 & le_mask;
		ge_s3   <= nw_s2 & ge_mask;
		base_s3 <= base2;

		if (v_s3 && search_q) begin
			if (|le_s3) begin
				lo_q <= base_s3 + PW'(le_idx);
			end
			if ((|ge_s3) && !hi_found_q) begin
				hi_q <= base_s3 + PW'(ge_idx);
			end
		end

		if (final_go) begin
			min_diff_q <= diff_next;
			ovf_out_q  <= ovf_q;
		end
	end

endmodule

FILE: rtl/core/ssnt_checker.sv
`timescale 1ns / 1ps

module ssnt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_stall,
	input logic                        last,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [ssnt_pkg::DIFF_W-1:0] min_difference,
	input logic                        overflow,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic                        pready,
	input logic [ssnt_pkg::APB_AW-1:0] paddr,
	input logic [ssnt_pkg::APB_DW-1:0] pwdata,
	input logic [ssnt_pkg::APB_DW-1:0] prdata
);
	import ssnt_pkg::*;

	logic wr_target;

	assign wr_target = psel && penable && pwrite && pready && (paddr[2] == 1'(REG_TARGET));

	// a last word always starts a sweep
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && last |=> item_stall)
		else $error("last word accepted but block not busy");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without a sweep");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(min_difference) && $stable(overflow))
		else $error("stalled result changed");

	a_target_readback: assert property (@(posedge clk) disable iff (!arst_n)
		wr_target |=> (paddr[2] != 1'(REG_TARGET)) ||
			(prdata[TARGET_W-1:0] == $past(pwdata[TARGET_W-1:0])))
		else $error("target readback mismatch");

endmodule

bind signed_sum_nearest_target ssnt_checker u_ssnt_checker (.*);
